/* hdl/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the peer session table: operation codes,
// controller states, fixed field widths and the per-cycle cell control word.
// ----------------------------------------------------------------------------
package pst_pkg;

   // fixed widths of the request and response fields
   localparam int KIND_W    = 2;
   localparam int PEER_ID_W = 64;
   localparam int TIME_W    = 32;
   localparam int RSP_IDX_W = 3;

   // operation codes carried in req_kind
   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP  = 2'd0,
      KIND_INSTALL = 2'd1,
      KIND_TOUCH   = 2'd2,
      KIND_SWEEP   = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // what the controller tells the ring of cells in a cycle
   typedef struct packed {
      logic shift;       // rotate the ring by one cell toward the head
      logic head_kill;   // drop the head entry as it wraps to the tail
      logic head_touch;  // give the wrapping head entry the write expiry
      logic load;        // write a new entry into the addressed cell
   } cell_ctrl_type;

endpackage

/* hdl/peer_session_table_with_expiry.sv */
// ----------------------------------------------------------------------------
// peer_session_table_with_expiry
// Session table kept in a rotating ring of slot cells, scanned at the head.
//
//   channel   ports                                        handshake
//   request   req_kind, req_peer_id, req_now_time,         start && !busy
//             req_ttl, req_new_expiry
//   response  rsp_found, rsp_slot_index, rsp_reused        rsp_strobe, 1 cycle
//
// The ring turns once past the head cell in ST_SCAN; ST_DONE then does the
// install write and loads the response registers, and rsp_strobe is
// registered from ST_DONE. busy is high from the accepting edge until the
// controller is back in ST_IDLE, so no new request is taken mid-pass.
// Reset clears all valid bits at once; the block is ready in the cycle after
// reset. The receiver cannot stall, so nothing holds the response.
// ----------------------------------------------------------------------------
module peer_session_table_with_expiry #(
   parameter int SLOTS     = 8,
   parameter int PEER_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pst_pkg::KIND_W-1:0]     req_kind,
   input  logic [pst_pkg::PEER_ID_W-1:0]  req_peer_id,
   input  logic [pst_pkg::TIME_W-1:0]     req_now_time,
   input  logic [pst_pkg::TIME_W-1:0]     req_ttl,
   input  logic [pst_pkg::TIME_W-1:0]     req_new_expiry,
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [pst_pkg::RSP_IDX_W-1:0]  rsp_slot_index,
   output logic                           rsp_reused
);
   import pst_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   cell_ctrl_type        cell_ctrl;
   logic [IDX_W-1:0]     load_idx;
   logic [PEER_BITS-1:0] wr_peer;
   logic [TIME_W-1:0]    wr_expiry;

   logic                 cell_valid  [SLOTS];
   logic [PEER_BITS-1:0] cell_peer   [SLOTS];
   logic [TIME_W-1:0]    cell_expiry [SLOTS];
   logic                 nb_valid    [SLOTS];
   logic [PEER_BITS-1:0] nb_peer     [SLOTS];
   logic [TIME_W-1:0]    nb_expiry   [SLOTS];

   logic                 wrap_valid;
   logic [TIME_W-1:0]    wrap_expiry;

   // head entry as it wraps around to the tail, after sweep or touch
   assign wrap_valid  = cell_valid[0] && !cell_ctrl.head_kill;
   assign wrap_expiry = cell_ctrl.head_touch ? wr_expiry : cell_expiry[0];

   // ring of slot cells, head at cell 0
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == SLOTS - 1) begin : g_tail
         assign nb_valid[i]  = wrap_valid;
         assign nb_peer[i]   = cell_peer[0];
         assign nb_expiry[i] = wrap_expiry;
      end else begin : g_body
         assign nb_valid[i]  = cell_valid[i+1];
         assign nb_peer[i]   = cell_peer[i+1];
         assign nb_expiry[i] = cell_expiry[i+1];
      end

      pst_cell #(
         .PEER_BITS (PEER_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (cell_ctrl.shift),
         .load        (cell_ctrl.load && (load_idx == IDX_W'(i))),
         .load_peer   (wr_peer),
         .load_expiry (wr_expiry),
         .nb_valid    (nb_valid[i]),
         .nb_peer     (nb_peer[i]),
         .nb_expiry   (nb_expiry[i]),
         .slot_valid  (cell_valid[i]),
         .slot_peer   (cell_peer[i]),
         .slot_expiry (cell_expiry[i])
      );
   end

   // scan controller
   pst_ctrl #(
      .SLOTS     (SLOTS),
      .PEER_BITS (PEER_BITS),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_peer_id    (req_peer_id),
      .req_now_time   (req_now_time),
      .req_ttl        (req_ttl),
      .req_new_expiry (req_new_expiry),
      .head_valid     (cell_valid[0]),
      .head_peer      (cell_peer[0]),
      .head_expiry    (cell_expiry[0]),
      .cell_ctrl      (cell_ctrl),
      .load_idx       (load_idx),
      .wr_peer        (wr_peer),
      .wr_expiry      (wr_expiry),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_slot_index (rsp_slot_index),
      .rsp_reused     (rsp_reused)
   );

endmodule

/* hdl/pst_cell.sv */
// ----------------------------------------------------------------------------
// pst_cell
// One slot of the session ring: valid bit, peer identifier and expiry time.
// Takes its neighbor's entry on a shift, or a new entry on a direct load.
// ----------------------------------------------------------------------------
module pst_cell #(
   parameter int PEER_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic                        load,
   input  logic [PEER_BITS-1:0]        load_peer,
   input  logic [pst_pkg::TIME_W-1:0]  load_expiry,
   input  logic                        nb_valid,
   input  logic [PEER_BITS-1:0]        nb_peer,
   input  logic [pst_pkg::TIME_W-1:0]  nb_expiry,
   output logic                        slot_valid,
   output logic [PEER_BITS-1:0]        slot_peer,
   output logic [pst_pkg::TIME_W-1:0]  slot_expiry
);
   import pst_pkg::*;

   logic                 valid_ff;
   logic [PEER_BITS-1:0] peer_ff;
   logic [TIME_W-1:0]    expiry_ff;

   // valid bit, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (shift) begin
         valid_ff <= nb_valid;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (load) begin
         peer_ff   <= load_peer;
         expiry_ff <= load_expiry;
      end else if (shift) begin
         peer_ff   <= nb_peer;
         expiry_ff <= nb_expiry;
      end
   end

   assign slot_valid  = valid_ff;
   assign slot_peer   = peer_ff;
   assign slot_expiry = expiry_ff;

endmodule

/* hdl/pst_ctrl.sv */
// ----------------------------------------------------------------------------
// pst_ctrl
// Scan controller: watches the head cell as the ring rotates once, tracks
// the first match, first free slot and soonest expiry, and issues the
// response and the install write at the end of the pass.
// ----------------------------------------------------------------------------
module pst_ctrl #(
   parameter int SLOTS     = 8,
   parameter int PEER_BITS = 64,
   parameter int IDX_W     = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pst_pkg::KIND_W-1:0]     req_kind,
   input  logic [pst_pkg::PEER_ID_W-1:0]  req_peer_id,
   input  logic [pst_pkg::TIME_W-1:0]     req_now_time,
   input  logic [pst_pkg::TIME_W-1:0]     req_ttl,
   input  logic [pst_pkg::TIME_W-1:0]     req_new_expiry,
   input  logic                           head_valid,
   input  logic [PEER_BITS-1:0]           head_peer,
   input  logic [pst_pkg::TIME_W-1:0]     head_expiry,
   output pst_pkg::cell_ctrl_type         cell_ctrl,
   output logic [IDX_W-1:0]               load_idx,
   output logic [PEER_BITS-1:0]           wr_peer,
   output logic [pst_pkg::TIME_W-1:0]     wr_expiry,
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [pst_pkg::RSP_IDX_W-1:0]  rsp_slot_index,
   output logic                           rsp_reused
);
   import pst_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type            state_ff, state_in;
   kind_type             kind_ff;
   logic [PEER_BITS-1:0] peer_ff;
   logic [TIME_W-1:0]    now_ff, ttl_ff, nexp_ff;
   logic [IDX_W-1:0]     cnt_ff;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]     cand_idx_ff, cand_idx_in;
   logic [TIME_W-1:0]    cand_exp_ff, cand_exp_in;
   logic                 strobe_ff, found_ff, reused_ff;
   logic [IDX_W-1:0]     idx_ff;

   logic                 accept;
   logic [TIME_W-1:0]    alive_diff, evict_diff;
   logic                 head_alive, peer_eq, head_match;
   logic [IDX_W-1:0]     pick_idx;
   logic                 done_found;
   logic [IDX_W+RSP_IDX_W-1:0] idx_wide;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // head liveness and peer compare with wrapping time
   assign alive_diff = head_expiry - now_ff;
   assign head_alive = (alive_diff != '0) && !alive_diff[TIME_W-1];
   assign evict_diff = head_expiry - cand_exp_ff;
   assign peer_eq    = (head_peer == peer_ff);
   assign head_match = head_valid && peer_eq;

   // install target: same peer, else first free, else soonest expiry
   always_comb begin
      priority if (hit_ff) begin
         pick_idx = hit_idx_ff;
      end else if (free_ff) begin
         pick_idx = free_idx_ff;
      end else begin
         pick_idx = cand_idx_ff;
      end
   end

   assign load_idx  = pick_idx;
   assign wr_peer   = peer_ff;
   assign wr_expiry = (kind_ff == KIND_TOUCH) ? nexp_ff : (now_ff + ttl_ff);

   // next state, scan tracking and cell control
   always_comb begin
      state_in    = state_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      cand_idx_in = cand_idx_ff;
      cand_exp_in = cand_exp_ff;
      cell_ctrl   = '0;
      done_found  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               hit_in   = 1'b0;
               free_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            cell_ctrl.shift = 1'b1;
            unique case (kind_ff)
               KIND_LOOKUP: begin
                  if (!hit_ff && head_match && head_alive) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cnt_ff;
                  end
               end
               KIND_INSTALL: begin
                  if (!hit_ff && head_match) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cnt_ff;
                  end
                  if (!free_ff && !head_valid) begin
                     free_in     = 1'b1;
                     free_idx_in = cnt_ff;
                  end
                  if (cnt_ff == '0 || evict_diff[TIME_W-1]) begin
                     cand_idx_in = cnt_ff;
                     cand_exp_in = head_expiry;
                  end
               end
               KIND_TOUCH: begin
                  if (!hit_ff && head_match) begin
                     hit_in               = 1'b1;
                     hit_idx_in           = cnt_ff;
                     cell_ctrl.head_touch = 1'b1;
                  end
               end
               KIND_SWEEP: begin
                  cell_ctrl.head_kill = head_valid && !head_alive;
               end
               default: ;
            endcase
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cell_ctrl.load = (kind_ff == KIND_INSTALL);
            done_found     = (kind_ff == KIND_INSTALL) ||
                             (((kind_ff == KIND_LOOKUP) || (kind_ff == KIND_TOUCH)) && hit_ff);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ST_DONE);
      end
   end

   // request capture, slot counter and scan trackers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         peer_ff <= req_peer_id[PEER_BITS-1:0];
         now_ff  <= req_now_time;
         ttl_ff  <= req_ttl;
         nexp_ff <= req_new_expiry;
         cnt_ff  <= '0;
      end else if (state_ff == ST_SCAN) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      cand_idx_ff <= cand_idx_in;
      cand_exp_ff <= cand_exp_in;
   end

   // response registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         found_ff  <= done_found;
         idx_ff    <= done_found ? pick_idx : '0;
         reused_ff <= (kind_ff == KIND_INSTALL) && hit_ff;
      end
   end

   // slot number reported through its low bits
   assign idx_wide       = {{RSP_IDX_W{1'b0}}, idx_ff};
   assign rsp_strobe     = strobe_ff;
   assign rsp_found      = found_ff;
   assign rsp_slot_index = idx_wide[RSP_IDX_W-1:0];
   assign rsp_reused     = reused_ff;

endmodule
